@@ rtl/spv_pkg.sv @@
// spv_pkg: types, constants and register codes for the saturated pursuit velocity block
// no dependencies
package spv_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int GAIN_W = 16;
	localparam int CAP_W = 23;
	localparam int POS_W = 32;
	localparam int VEL_W = 24;
	localparam int DIFF_W = POS_W + 1;
	localparam int SQ_W = 2 * DIFF_W + 2;
	localparam int LEN_W = DIFF_W + 1;
	localparam int PROD_W = DIFF_W + CAP_W;
	localparam int OUT_LIM = 4194304;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd13107;
	localparam int CAP_RESET_INT = 7;

	typedef enum logic [0:0] {
		REG_GAIN = 1'b0,
		REG_SPEED_CAP = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic signed [POS_W-1:0] target_x;
		logic signed [POS_W-1:0] target_y;
		logic signed [POS_W-1:0] target_z;
		logic signed [POS_W-1:0] own_x;
		logic signed [POS_W-1:0] own_y;
		logic signed [POS_W-1:0] own_z;
		logic chase_start;
	} in_item_t;

	typedef struct packed {
		logic signed [VEL_W-1:0] vel_x;
		logic signed [VEL_W-1:0] vel_y;
		logic signed [VEL_W-1:0] vel_z;
	} out_item_t;

	// classified item handed from front to back
	typedef struct packed {
		logic [2:0] neg;
		logic [DIFF_W-1:0] mag_x;
		logic [DIFF_W-1:0] mag_y;
		logic [DIFF_W-1:0] mag_z;
		logic zero;
		logic [SQ_W-1:0] sumsq;
	} work_t;

	function automatic logic [CAP_W-1:0] cap_reset(input int frac);
		logic [63:0] v;
		begin
			v = 64'(CAP_RESET_INT) << frac;
			cap_reset = (v > 64'h7FFFFF) ? {CAP_W{1'b1}} : v[CAP_W-1:0];
		end
	endfunction

endpackage

@@ rtl/spv_front.sv @@
// spv_front: accepts position pairs, forms differences and the squared length
// depends on spv_pkg
module spv_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid,
	output logic              stall,
	input  spv_pkg::in_item_t in_data,
	output logic              wvalid,
	input  logic              wstall,
	output spv_pkg::work_t    wdata
);
	import spv_pkg::*;

	logic signed [DIFF_W-1:0] dx, dy, dz;
	logic [DIFF_W-1:0] mx, my, mz;
	logic [2*DIFF_W-1:0] px_s1, py_s1, pz_s1;
	logic [DIFF_W-1:0] mx_s1, my_s1, mz_s1;
	logic [2:0] neg_s1;
	logic zero_s1, v_s1;
	logic adv1;
	work_t w_s2;
	logic v_s2;

	assign dx = DIFF_W'(in_data.target_x) - DIFF_W'(in_data.own_x);
	assign dy = DIFF_W'(in_data.target_y) - DIFF_W'(in_data.own_y);
	assign dz = DIFF_W'(in_data.target_z) - DIFF_W'(in_data.own_z);
	assign mx = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
	assign my = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
	assign mz = dz[DIFF_W-1] ? DIFF_W'(-dz) : DIFF_W'(dz);

	assign adv1 = !(v_s2 && wstall);
	assign stall = !adv1 && v_s1;

	// squares are 33x33, cut here before the sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (!stall) v_s1 <= valid;
			if (adv1) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall && valid) begin
			px_s1 <= mx * mx;
			py_s1 <= my * my;
			pz_s1 <= mz * mz;
			mx_s1 <= mx;
			my_s1 <= my;
			mz_s1 <= mz;
			neg_s1 <= {dx[DIFF_W-1], dy[DIFF_W-1], dz[DIFF_W-1]};
			zero_s1 <= in_data.chase_start;
		end
		if (adv1 && v_s1) begin
			w_s2.sumsq <= SQ_W'(px_s1) + SQ_W'(py_s1) + SQ_W'(pz_s1);
			w_s2.mag_x <= mx_s1;
			w_s2.mag_y <= my_s1;
			w_s2.mag_z <= mz_s1;
			w_s2.neg <= neg_s1;
			w_s2.zero <= zero_s1;
		end
	end

	assign wvalid = v_s2;
	assign wdata = w_s2;
endmodule

@@ rtl/spv_queue.sv @@
// spv_queue: short queue between front and back
// depends on spv_pkg
module spv_queue #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  spv_pkg::work_t in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output spv_pkg::work_t out_data
);
	import spv_pkg::*;
	localparam int AW = $clog2(DEPTH);

	work_t mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic push, pop;

	assign in_stall = (cnt_q == (AW+1)'(DEPTH));
	assign out_valid = (cnt_q != '0);
	assign push = in_valid && !in_stall;
	assign pop = out_valid && !out_stall;
	assign out_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (pop) rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_data;
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= (AW+1)'(DEPTH))
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue push lost");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> !pop)
		else $error("queue pop while empty");
endmodule

@@ rtl/spv_back.sv @@
// spv_back: pipelined square root, speed limit and per-axis division
// depends on spv_pkg
module spv_back #(
	parameter int FRAC_BITS = spv_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wvalid,
	output logic                       wstall,
	input  spv_pkg::work_t             wdata,
	input  logic [spv_pkg::GAIN_W-1:0] gain,
	input  logic [spv_pkg::CAP_W-1:0]  speed_cap,
	output logic                       valid,
	input  logic                       stall,
	output spv_pkg::out_item_t         out_data
);
	import spv_pkg::*;

	localparam int SQS = LEN_W;        // one root bit per stage
	localparam int DVS = PROD_W;       // one quotient bit per stage
	localparam int NS = SQS + 2 + DVS + 1;

	// global pipeline enable: whole pipe moves unless output beat is held
	logic en;
	logic [NS:0] v_q;
	assign en = !(v_q[NS] && stall);
	assign wstall = !en;

	// square root stages: remainder, root, passthrough
	logic [SQ_W-1:0] sq_n [SQS+1];
	logic [LEN_W-1:0] sq_r [SQS+1];
	work_t sq_w [SQS+1];

	assign sq_n[0] = wdata.sumsq;
	assign sq_r[0] = '0;
	assign sq_w[0] = wdata;

	for (genvar s = 0; s < SQS; s++) begin : g_sqrt
		localparam int B = SQS - 1 - s;
		logic [SQ_W+1:0] t;
		logic take;
		// trial term 2*r*2^B + 2^(2B) from the root so far, shifts and adds only
		assign t = ((SQ_W+2)'(sq_r[s]) << (B + 1)) + ((SQ_W+2)'(1) << (2 * B));
		assign take = t <= (SQ_W+2)'(sq_n[s]);
		always_ff @(posedge clk) begin
			if (en) begin
				sq_n[s+1] <= take ? SQ_W'((SQ_W+2)'(sq_n[s]) - t) : sq_n[s];
				sq_w[s+1] <= sq_w[s];
				sq_r[s+1] <= take ? (sq_r[s] | (LEN_W'(1) << B)) : sq_r[s];
			end
		end
	end

	// speed stage: gain*len, then cap
	logic [LEN_W+GAIN_W-1:0] gl_s1;
	logic [LEN_W-1:0] len_s1, len_s2;
	work_t w_s1, w_s2;
	logic [CAP_W-1:0] spd_s2;
	logic [LEN_W+GAIN_W-1:0] spd_full;

	assign spd_full = gl_s1 >> GAIN_W;

	always_ff @(posedge clk) begin
		if (en) begin
			gl_s1 <= sq_r[SQS] * gain;
			len_s1 <= sq_r[SQS];
			w_s1 <= sq_w[SQS];
			len_s2 <= len_s1;
			w_s2 <= w_s1;
			spd_s2 <= (spd_full > (LEN_W+GAIN_W)'(speed_cap)) ? speed_cap
				: CAP_W'(spd_full);
		end
	end

	// numerators mag*speed, then restoring division by len
	logic [PROD_W-1:0] num [3];
	logic [PROD_W-1:0] dv_n [3][DVS+1];
	logic [PROD_W:0] dv_rem [3][DVS+1];
	logic [PROD_W-1:0] dv_q [3][DVS+1];
	logic [LEN_W-1:0] dv_d [DVS+1];
	work_t dv_w [DVS+1];
	logic [DIFF_W-1:0] mag2 [3];

	assign mag2[0] = w_s2.mag_x;
	assign mag2[1] = w_s2.mag_y;
	assign mag2[2] = w_s2.mag_z;

	always_ff @(posedge clk) begin
		if (en) begin
			dv_d[0] <= len_s2;
			dv_w[0] <= w_s2;
		end
	end

	for (genvar a = 0; a < 3; a++) begin : g_ax
		assign dv_rem[a][0] = '0;
		assign dv_q[a][0] = '0;
		assign num[a] = dv_n[a][0];
		always_ff @(posedge clk) begin
			if (en) dv_n[a][0] <= mag2[a] * spd_s2;
		end
		for (genvar s = 0; s < DVS; s++) begin : g_div
			logic [PROD_W:0] t;
			logic ge;
			assign t = {dv_rem[a][s][PROD_W-1:0], dv_n[a][s][PROD_W-1-s]};
			assign ge = t >= (PROD_W+1)'(dv_d[s]);
			always_ff @(posedge clk) begin
				if (en) begin
					dv_n[a][s+1] <= dv_n[a][s];
					dv_rem[a][s+1] <= ge ? t - (PROD_W+1)'(dv_d[s]) : t;
					dv_q[a][s+1] <= {dv_q[a][s][PROD_W-2:0], ge};
				end
			end
		end
	end

	for (genvar s = 0; s < DVS; s++) begin : g_dpass
		always_ff @(posedge clk) begin
			if (en) begin
				dv_d[s+1] <= dv_d[s];
				dv_w[s+1] <= dv_w[s];
			end
		end
	end

	// saturate, sign and zero cases
	logic signed [VEL_W-1:0] vel [3];
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			logic [VEL_W-1:0] m;
			m = (dv_q[a][DVS] > PROD_W'(OUT_LIM)) ? VEL_W'(OUT_LIM)
				: VEL_W'(dv_q[a][DVS]);
			if (dv_w[DVS].zero || dv_d[DVS] == '0) vel[a] = '0;
			else vel[a] = dv_w[DVS].neg[2-a] ? -$signed(m) : $signed(m);
		end
	end

	out_item_t out_q;
	always_ff @(posedge clk) begin
		if (en) begin
			out_q.vel_x <= vel[0];
			out_q.vel_y <= vel[1];
			out_q.vel_z <= vel[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[NS-1:0], wvalid};
		end
	end

	assign valid = v_q[NS];
	assign out_data = out_q;

	logic unused_num;
	assign unused_num = ^{num[0], num[1], num[2], FRAC_BITS[0]};

	assert property (@(posedge clk) disable iff (!arst_n)
		(valid && stall) |=> valid)
		else $error("result dropped while held");
	assert property (@(posedge clk) disable iff (!arst_n)
		(wvalid && !wstall) |-> ##0 en)
		else $error("entry taken while pipe frozen");
	assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (out_q.vel_x <= $signed(VEL_W'(OUT_LIM)))
			&& (out_q.vel_x >= -$signed(VEL_W'(OUT_LIM))))
		else $error("x velocity out of range");
endmodule

@@ rtl/saturated_pursuit_velocity_top.sv @@
// Saturated pursuit velocity controller: takes one position pair per cycle while
// in_stall is low and returns one velocity per item, in order. Each item passes two front
// stages, the queue, then 94 back stages (34-stage square root, two speed stages, the
// numerator product, a 56-stage divider and the output register). A held output beat
// freezes the back pipeline; the four-entry queue absorbs that before the input stalls.
// depends on spv_pkg
module saturated_pursuit_velocity_top #(
	parameter int FRAC_BITS = spv_pkg::FRAC_BITS_DEF,
	parameter int QDEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  spv_pkg::in_item_t          in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output spv_pkg::out_item_t         out_data,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [0:0]                 cfg_index,
	input  logic [31:0]                cfg_data
);
	import spv_pkg::*;

	logic [GAIN_W-1:0] gain_q;
	logic [CAP_W-1:0] cap_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
			cap_q <= cap_reset(FRAC_BITS);
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_GAIN: gain_q <= cfg_data[GAIN_W-1:0];
				REG_SPEED_CAP: cap_q <= cfg_data[CAP_W-1:0];
				default: ;
			endcase
		end
	end

	logic fv, fs, qv, qs;
	work_t fd, qd;

	spv_front u_front (
		.clk, .arst_n, .valid(in_valid), .stall(in_stall), .in_data,
		.wvalid(fv), .wstall(fs), .wdata(fd)
	);

	spv_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk, .arst_n, .in_valid(fv), .in_stall(fs), .in_data(fd),
		.out_valid(qv), .out_stall(qs), .out_data(qd)
	);

	spv_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk, .arst_n, .wvalid(qv), .wstall(qs), .wdata(qd),
		.gain(gain_q), .speed_cap(cap_q),
		.valid(out_valid), .stall(out_stall), .out_data
	);
endmodule

@@ tb/tb_top.sv @@
// tb_top: self-checking bench for saturated_pursuit_velocity_top, bursty input beats,
// patterned output stall, config phases, and a bit-accurate velocity predictor
// depends on spv_pkg and the rtl top level
module tb_top;
	import spv_pkg::*;

	localparam int DRAIN_CYCLES = 160;
	localparam int IDLE_LIMIT = 6000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [0:0] cfg_index = REG_GAIN;
	logic [31:0] cfg_data = '0;

	saturated_pursuit_velocity_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	logic [GAIN_W-1:0] gain_q = GAIN_RESET;
	logic [CAP_W-1:0] cap_q = cap_reset(FRAC_BITS_DEF);
	in_item_t pend_q[$];
	out_item_t vel_q[$];
	int errors = 0;
	int idle_cnt = 0;
	logic in_took = 1'b0;
	int burst_left = 0;
	int gap_left = 0;
	int stall_mode = 0;
	int stall_ctr = 0;

	function automatic logic [33:0] floor_sqrt(input logic [67:0] n);
		logic [33:0] r;
		logic [33:0] c;
		begin
			r = '0;
			for (int b = 33; b >= 0; b--) begin
				c = r | (34'd1 << b);
				if (68'(c) * 68'(c) <= n)
					r = c;
			end
			return r;
		end
	endfunction

	function automatic out_item_t pursuit_velocity(input in_item_t it);
		logic signed [32:0] d [3];
		logic [32:0] mag [3];
		logic [67:0] sumsq;
		logic [33:0] len;
		logic [63:0] speed;
		logic [63:0] m;
		logic signed [23:0] v [3];
		out_item_t o;
		begin
			d[0] = 33'(it.target_x) - 33'(it.own_x);
			d[1] = 33'(it.target_y) - 33'(it.own_y);
			d[2] = 33'(it.target_z) - 33'(it.own_z);
			sumsq = '0;
			for (int i = 0; i < 3; i++) begin
				mag[i] = d[i] < 0 ? 33'(-d[i]) : 33'(d[i]);
				sumsq += 68'(mag[i]) * 68'(mag[i]);
			end
			len = floor_sqrt(sumsq);
			speed = (64'(gain_q) * 64'(len)) >> 16;
			if (speed > 64'(cap_q))
				speed = 64'(cap_q);
			for (int i = 0; i < 3; i++) begin
				v[i] = '0;
				if (!it.chase_start && len != 0) begin
					m = (64'(mag[i]) * speed) / 64'(len);
					if (m > 64'(OUT_LIM))
						m = 64'(OUT_LIM);
					v[i] = d[i] < 0 ? -24'(m) : 24'(m);
				end
			end
			o.vel_x = v[0];
			o.vel_y = v[1];
			o.vel_z = v[2];
			return o;
		end
	endfunction

	function automatic logic [31:0] rand_offset();
		logic [31:0] r;
		begin
			r = $urandom() >> $urandom_range(0, 31);
			return $urandom_range(0, 1) ? -r : r;
		end
	endfunction

	function automatic in_item_t rand_track();
		in_item_t it;
		int kind;
		begin
			kind = $urandom_range(0, 15);
			it.target_x = $urandom();
			it.target_y = $urandom();
			it.target_z = $urandom();
			it.own_x = $urandom();
			it.own_y = $urandom();
			it.own_z = $urandom();
			it.chase_start = ($urandom_range(0, 7) == 0);
			if (kind < 11) begin
				it.own_x = it.target_x + rand_offset();
				it.own_y = it.target_y + rand_offset();
				it.own_z = it.target_z + rand_offset();
			end else if (kind < 12) begin
				it.own_x = it.target_x;
				it.own_y = it.target_y;
				it.own_z = it.target_z;
			end else if (kind < 13) begin
				it.own_x = it.target_x;
				it.own_y = it.target_y;
				it.own_z = it.target_z + rand_offset();
			end
			return it;
		end
	endfunction

	function automatic in_item_t mk(input logic [31:0] tx, ty, tz, ox, oy, oz,
			input logic cs);
		in_item_t it;
		begin
			it.target_x = tx; it.target_y = ty; it.target_z = tz;
			it.own_x = ox; it.own_y = oy; it.own_z = oz;
			it.chase_start = cs;
			return it;
		end
	endfunction

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == REG_GAIN)
			gain_q = val[GAIN_W-1:0];
		else
			cap_q = val[CAP_W-1:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pend_q.size() != 0 || in_valid || vel_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic queue_random(input int n);
		for (int i = 0; i < n; i++)
			pend_q.push_back(rand_track());
	endtask

	// input driver
	always @(negedge clk) begin
		if (!(in_valid && !in_took)) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pend_q.size() != 0) begin
				in_valid <= 1'b1;
				in_data <= pend_q.pop_front();
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
				end else
					burst_left <= burst_left - 1;
			end else
				in_valid <= 1'b0;
		end
	end

	// output stall pattern
	always @(negedge clk) begin
		if (stall_ctr == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_ctr <= $urandom_range(16, 96);
		end else
			stall_ctr <= stall_ctr - 1;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= stall_ctr[2];
		endcase
	end

	// accept and check
	always @(posedge clk) begin
		out_item_t want;
		in_took <= in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall)
			vel_q.push_back(pursuit_velocity(in_data));
		if (arst_n && out_valid && !out_stall) begin
			if (vel_q.size() == 0) begin
				$error("result beat with nothing expected: %h", out_data);
				errors++;
			end else begin
				want = vel_q.pop_front();
				if (out_data.vel_x !== want.vel_x) begin
					$error("vel_x expected %0d got %0d", want.vel_x, out_data.vel_x);
					errors++;
				end
				if (out_data.vel_y !== want.vel_y) begin
					$error("vel_y expected %0d got %0d", want.vel_y, out_data.vel_y);
					errors++;
				end
				if (out_data.vel_z !== want.vel_z) begin
					$error("vel_z expected %0d got %0d", want.vel_z, out_data.vel_z);
					errors++;
				end
			end
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, coincident, first tick, single axes
		pend_q.push_back(mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h80000000, 32'h80000000, 32'h80000000, 1'b0));
		pend_q.push_back(mk(32'h80000000, 32'h80000000, 32'h80000000,
			32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0));
		pend_q.push_back(mk(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
			32'h80000000, 32'h7FFFFFFF, 32'h80000000, 1'b0));
		pend_q.push_back(mk(32'h7FFFFFFF, 32'h80000000, 0, 32'h7FFFFFFF, 32'h80000000, 0, 1'b0));
		pend_q.push_back(mk(0, 0, 0, 0, 0, 0, 1'b0));
		pend_q.push_back(mk(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
			32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1));
		pend_q.push_back(mk(32'h00100000, 32'h00050000, 32'hFFF00000, 0, 0, 0, 1'b1));
		pend_q.push_back(mk(32'h00100000, 32'h00050000, 32'hFFF00000, 0, 0, 0, 1'b0));
		pend_q.push_back(mk(1, 0, 0, 0, 0, 0, 1'b0));
		pend_q.push_back(mk(0, 32'hFFFFFFFF, 0, 0, 0, 0, 1'b0));
		pend_q.push_back(mk(0, 0, 32'h00010000, 0, 0, 0, 1'b0));
		pend_q.push_back(mk(32'h00230000, 0, 0, 0, 0, 0, 1'b0));
		pend_q.push_back(mk(0, 32'hFFDD0000, 0, 0, 0, 0, 1'b0));
		pend_q.push_back(mk(32'h00030000, 32'h00040000, 0, 0, 0, 32'h000C0000, 1'b0));
		queue_random(230);
		wait_idle();

		// largest gain and cap, output clamp reachable
		write_reg(REG_GAIN, 32'h0000FFFF);
		write_reg(REG_SPEED_CAP, 32'hFFFFFFFF);
		pend_q.push_back(mk(32'h7FFFFFFF, 0, 0, 32'h80000000, 0, 0, 1'b0));
		pend_q.push_back(mk(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h7FFFFFFF, 32'h80000000, 32'h80000000, 1'b0));
		queue_random(200);
		wait_idle();

		write_reg(REG_GAIN, 32'hABCD0000);
		write_reg(REG_SPEED_CAP, 32'h00000000);
		queue_random(120);
		wait_idle();

		write_reg(REG_GAIN, 32'h00000001);
		write_reg(REG_SPEED_CAP, 32'h00400000);
		queue_random(150);
		wait_idle();

		write_reg(REG_GAIN, $urandom());
		write_reg(REG_SPEED_CAP, $urandom());
		queue_random(150);
		wait_idle();

		write_reg(REG_GAIN, 32'd13107);
		write_reg(REG_SPEED_CAP, 32'h00070000);
		queue_random(150);
		wait_idle();

		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
